FILE: rtl/ata_tf_pkg.sv
`timescale 1ns / 1ps

package ata_tf_pkg;

	// Request type codes.
	localparam logic [1:0] REQ_READ      = 2'd0;
	localparam logic [1:0] REQ_WRITE     = 2'd1;
	localparam logic [1:0] REQ_BUS_RESET = 2'd2;

	// Task file register numbers (command block 0-7, control block 8-15).
	localparam logic [3:0] REG_ERR_FEAT   = 4'd1;
	localparam logic [3:0] REG_COUNT      = 4'd2;
	localparam logic [3:0] REG_SECTOR     = 4'd3;
	localparam logic [3:0] REG_CYL_LO     = 4'd4;
	localparam logic [3:0] REG_CYL_HI     = 4'd5;
	localparam logic [3:0] REG_DRIVE_HEAD = 4'd6;
	localparam logic [3:0] REG_CMD_STATUS = 4'd7;
	localparam logic [3:0] REG_DEV_CTRL   = 4'd14;

	// Register bit fields and byte constants.
	localparam int unsigned DH_DRIVE_BIT    = 4;
	localparam int unsigned DC_SRST_BIT     = 2;
	localparam int unsigned DC_NIEN_BIT     = 1;
	localparam int unsigned STS_ERR_BIT     = 0;
	localparam logic [7:0]  DH_FIXED_BITS   = 8'ha0;
	localparam logic [7:0]  ERR_ABORT       = 8'h04;
	localparam logic [7:0]  CMD_SET_FEATURES = 8'hef;
	localparam logic [7:0]  FEAT_PIO8       = 8'h01;
	localparam logic [7:0]  BYTE_FLOAT      = 8'hff;
	localparam logic [7:0]  BYTE_ZERO       = 8'h00;
	localparam logic [1:0]  DRIVES_RESET    = 2'b01;

	localparam int unsigned NUM_DRIVES = 2;

	typedef struct packed {
		logic [1:0] req_type;
		logic [3:0] reg_index;
		logic [7:0] write_data;
	} tf_req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       irq_pending;
		logic       irq_disabled;
		logic [1:0] pio8_mask;
	} tf_result_t;

	// Per-drive copy of the shadowed task file registers.
	typedef struct packed {
		logic [7:0] err;
		logic [7:0] cnt;
		logic [7:0] sec;
		logic [7:0] clo;
		logic [7:0] chi;
		logic [7:0] sts;
	} drive_regs_t;

	localparam drive_regs_t DRIVE_RESET = '{
		err: 8'h01, cnt: 8'h01, sec: 8'h01, clo: 8'h00, chi: 8'h00, sts: 8'h40
	};

endpackage

FILE: rtl/ata_tf_regs.sv
`timescale 1ns / 1ps

module ata_tf_regs (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_drives,
	input  logic                   req_valid,
	input  ata_tf_pkg::tf_req_t    req,
	output ata_tf_pkg::tf_result_t res
);
	import ata_tf_pkg::*;

	drive_regs_t drv_q [NUM_DRIVES];
	drive_regs_t drv_d [NUM_DRIVES];
	logic [7:0]  feat_q, feat_d;
	logic [7:0]  dh_q, dh_d;
	logic [7:0]  devctl_q, devctl_d;
	logic        int_q, int_d;
	logic [1:0]  pio8_q, pio8_d;
	logic [1:0]  drives_q;

	logic [1:0]  present;
	logic        any_present;
	logic        sel;
	logic        is_status;
	logic        cmd_ok;
	logic [7:0]  sel_val;
	logic [7:0]  rd;

	// A drive answers only while attached and soft reset is clear.
	assign present     = drives_q & {NUM_DRIVES{~devctl_q[DC_SRST_BIT]}};
	assign any_present = |present;
	assign sel         = dh_q[DH_DRIVE_BIT];
	assign is_status   = (req.reg_index == REG_CMD_STATUS) || (req.reg_index == REG_DEV_CTRL);
	assign cmd_ok      = (req.write_data == CMD_SET_FEATURES) && (feat_q == FEAT_PIO8);

	// Field of the selected drive that a read of this register returns.
	always_comb begin
		case (req.reg_index)
			REG_ERR_FEAT: sel_val = drv_q[sel].err;
			REG_COUNT:    sel_val = drv_q[sel].cnt;
			REG_SECTOR:   sel_val = drv_q[sel].sec;
			REG_CYL_LO:   sel_val = drv_q[sel].clo;
			REG_CYL_HI:   sel_val = drv_q[sel].chi;
			default:      sel_val = drv_q[sel].sts;
		endcase
	end

	// Next state and read data for the transaction at the input.
	always_comb begin
		drv_d    = drv_q;
		feat_d   = feat_q;
		dh_d     = dh_q;
		devctl_d = devctl_q;
		int_d    = int_q;
		pio8_d   = pio8_q;
		rd       = BYTE_ZERO;
		unique case (req.req_type)
			REQ_READ: begin
				unique case (req.reg_index) inside
					REG_ERR_FEAT, REG_COUNT, REG_SECTOR, REG_CYL_LO, REG_CYL_HI,
					REG_CMD_STATUS, REG_DEV_CTRL: begin
						if (present[sel]) begin
							rd = sel_val;
							if (req.reg_index == REG_CMD_STATUS) begin
								int_d = 1'b0;
							end
						end else if (devctl_q[DC_SRST_BIT]) begin
							rd = BYTE_FLOAT;
						end else if (is_status && sel && present[0]) begin
							rd = BYTE_ZERO;
						end else begin
							rd = BYTE_FLOAT;
						end
					end
					REG_DRIVE_HEAD: begin
						rd = any_present ? dh_q : BYTE_FLOAT;
					end
					default: begin
						rd = BYTE_FLOAT;
					end
				endcase
			end
			REQ_WRITE: begin
				unique case (req.reg_index) inside
					REG_ERR_FEAT: begin
						if (any_present) begin
							feat_d = req.write_data;
						end
					end
					REG_COUNT, REG_SECTOR, REG_CYL_LO, REG_CYL_HI: begin
						for (int d = 0; d < NUM_DRIVES; d++) begin
							if (present[d]) begin
								case (req.reg_index)
									REG_COUNT:  drv_d[d].cnt = req.write_data;
									REG_SECTOR: drv_d[d].sec = req.write_data;
									REG_CYL_LO: drv_d[d].clo = req.write_data;
									default:    drv_d[d].chi = req.write_data;
								endcase
							end
						end
					end
					REG_DRIVE_HEAD: begin
						if (any_present) begin
							dh_d = req.write_data | DH_FIXED_BITS;
						end
					end
					REG_CMD_STATUS: begin
						// Commands complete at once; anything but SET FEATURES 8-bit PIO aborts.
						if (any_present) begin
							drv_d[sel].sts[STS_ERR_BIT] = ~cmd_ok;
							if (cmd_ok) begin
								pio8_d[sel] = 1'b1;
							end else begin
								drv_d[sel].err = ERR_ABORT;
							end
							int_d = 1'b1;
						end
					end
					REG_DEV_CTRL: begin
						if (req.write_data[DC_SRST_BIT]) begin
							int_d = 1'b0;
						end
						devctl_d = req.write_data;
					end
					default: begin
					end
				endcase
			end
			REQ_BUS_RESET: begin
				for (int d = 0; d < NUM_DRIVES; d++) begin
					drv_d[d] = DRIVE_RESET;
				end
				feat_d = BYTE_ZERO;
				dh_d   = DH_FIXED_BITS;
			end
			default: begin
			end
		endcase
	end

	// Result reflects the state after this transaction.
	always_comb begin
		res.read_data    = rd;
		res.irq_pending  = int_d;
		res.irq_disabled = devctl_d[DC_NIEN_BIT];
		res.pio8_mask    = pio8_d;
	end

	// Task file state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < NUM_DRIVES; d++) begin
				drv_q[d] <= DRIVE_RESET;
			end
			feat_q   <= BYTE_ZERO;
			dh_q     <= DH_FIXED_BITS;
			devctl_q <= BYTE_ZERO;
			int_q    <= 1'b0;
			pio8_q   <= 2'b00;
		end else if (req_valid) begin
			drv_q    <= drv_d;
			feat_q   <= feat_d;
			dh_q     <= dh_d;
			devctl_q <= devctl_d;
			int_q    <= int_d;
			pio8_q   <= pio8_d;
		end
	end

	// Attached-drive configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drives_q <= DRIVES_RESET;
		end else if (cfg_we) begin
			drives_q <= cfg_drives;
		end
	end

endmodule

FILE: rtl/ata_task_file_register_block.sv
`timescale 1ns / 1ps

// Eight-bit ATA task file for two drives. Each input transaction is a register
// read, a register write or a bus reset, and it yields exactly one result
// transaction carrying the read byte, the pending interrupt, the interrupt
// disable bit and the 8-bit PIO mask. A transaction can be accepted every cycle
// while the skid register is empty; its result enters the output register, or the
// skid register if the output is held. The task file state is updated by
// single-level decode logic in the cycle of acceptance, and the two-entry output
// buffer keeps the input ready while one result waits for the consumer. The
// drives_present register is written through the cfg channel, which is always
// ready, and must only be written while no transaction is outstanding.
module ata_task_file_register_block (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  ata_tf_pkg::tf_req_t    in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output ata_tf_pkg::tf_result_t out_data,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [1:0]             cfg_data
);
	import ata_tf_pkg::*;

	tf_result_t res;
	tf_result_t out_data_q;
	tf_result_t skid_data_q;
	logic       out_valid_q;
	logic       skid_valid_q;
	logic       in_accept;
	logic       out_take;
	logic       load_out;

	assign cfg_ready = 1'b1;
	assign in_ready  = ~skid_valid_q;
	assign in_accept = in_valid & in_ready;
	assign out_take  = out_valid_q & out_ready;
	assign load_out  = ~out_valid_q | out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	ata_tf_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_valid & cfg_ready),
		.cfg_drives (cfg_data),
		.req_valid  (in_accept),
		.req        (in_data),
		.res        (res)
	);

	// Output and skid valid flags. The skid entry only fills while the output
	// entry is held, so a filled skid entry always moves up on the next take.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			out_valid_q  <= in_accept | skid_valid_q | (out_valid_q & ~out_ready);
			skid_valid_q <= (skid_valid_q | in_accept) & out_valid_q & ~out_ready;
		end
	end

	// Result payload registers.
	always_ff @(posedge clk) begin
		if (out_take && skid_valid_q) begin
			out_data_q <= skid_data_q;
		end else if (in_accept && load_out) begin
			out_data_q <= res;
		end
		if (in_accept && !load_out) begin
			skid_data_q <= res;
		end
	end

endmodule

FILE: rtl/ata_tf_checker.sv
`timescale 1ns / 1ps

module ata_tf_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input ata_tf_pkg::tf_result_t out_data
);
	import ata_tf_pkg::*;

	// A stalled result transaction holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// The input only stalls when a result is already waiting.
	a_stall_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with empty output");

	// An accepted transaction into an empty output shows up the next cycle.
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && in_valid && in_ready |=> out_valid)
		else $error("result missing one cycle after acceptance");

	// With results flowing freely the input never stalls.
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready && $past(out_ready) |-> in_ready)
		else $error("input stalled while output drains");

endmodule

bind ata_task_file_register_block ata_tf_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

FILE: dv/ata_task_file_checker.sv
`timescale 1ns / 1ps

// Watches the request, result and configuration channels of the task file
// block. It keeps its own copy of both drives' registers, works out the
// response of every accepted request, and compares results in order.
module ata_task_file_checker (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_ready,
	input  ata_tf_pkg::tf_req_t    in_data,
	input  logic                   out_valid,
	input  logic                   out_ready,
	input  ata_tf_pkg::tf_result_t out_data,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [1:0]             cfg_data,
	output int                     fail_count,
	output int                     results_checked,
	output int                     outstanding
);
	import ata_tf_pkg::*;

	typedef struct packed {
		tf_req_t    req;
		tf_result_t res;
	} awaited_t;

	awaited_t    awaited_responses [$];

	// Shadow copy of the task file and the drive presence setting.
	logic [1:0]  present_cfg;
	drive_regs_t shadow [NUM_DRIVES];
	logic [7:0]  features;
	logic [7:0]  drive_head;
	logic [7:0]  command;
	logic [7:0]  dev_ctrl;
	logic        irq_flag;
	logic [1:0]  pio8;

	// A drive answers only when attached and soft reset is not held.
	function automatic logic drive_on(input int d);
		return !dev_ctrl[DC_SRST_BIT] && present_cfg[d];
	endfunction

	function automatic logic any_on();
		return drive_on(0) || drive_on(1);
	endfunction

	// Bus reset leaves device control, the interrupt and the PIO mask alone.
	function automatic void reset_task_file();
		foreach (shadow[d]) shadow[d] = DRIVE_RESET;
		features   = '0;
		drive_head = DH_FIXED_BITS;
		command    = '0;
	endfunction

	// Applies one request to the shadow task file and returns its response.
	function automatic tf_result_t access_response(input tf_req_t req);
		tf_result_t res;
		int         d;
		int         i;
		logic       is_status;
		res = '0;
		d = int'(drive_head[DH_DRIVE_BIT]);
		is_status = (req.reg_index == REG_CMD_STATUS) || (req.reg_index == REG_DEV_CTRL);
		case (req.req_type)
			REQ_READ: begin
				case (req.reg_index)
					REG_ERR_FEAT, REG_COUNT, REG_SECTOR, REG_CYL_LO, REG_CYL_HI,
					REG_CMD_STATUS, REG_DEV_CTRL: begin
						if (drive_on(d)) begin
							case (req.reg_index)
								REG_ERR_FEAT: res.read_data = shadow[d].err;
								REG_COUNT:    res.read_data = shadow[d].cnt;
								REG_SECTOR:   res.read_data = shadow[d].sec;
								REG_CYL_LO:   res.read_data = shadow[d].clo;
								REG_CYL_HI:   res.read_data = shadow[d].chi;
								default:      res.read_data = shadow[d].sts;
							endcase
							// Only the primary status port acknowledges the interrupt.
							if (req.reg_index == REG_CMD_STATUS) irq_flag = 1'b0;
						end else if (is_status && d == 1 && drive_on(0)) begin
							// Drive 0 drives the status lines low for a missing drive 1.
							res.read_data = BYTE_ZERO;
						end else begin
							res.read_data = BYTE_FLOAT;
						end
					end
					REG_DRIVE_HEAD: res.read_data = any_on() ? drive_head : BYTE_FLOAT;
					default:        res.read_data = BYTE_FLOAT;
				endcase
			end
			REQ_WRITE: begin
				case (req.reg_index)
					REG_ERR_FEAT: if (any_on()) features = req.write_data;
					REG_COUNT, REG_SECTOR, REG_CYL_LO, REG_CYL_HI: begin
						// Shared registers land in every attached drive's copy.
						for (i = 0; i < NUM_DRIVES; i++) begin
							if (drive_on(i)) begin
								case (req.reg_index)
									REG_COUNT:  shadow[i].cnt = req.write_data;
									REG_SECTOR: shadow[i].sec = req.write_data;
									REG_CYL_LO: shadow[i].clo = req.write_data;
									default:    shadow[i].chi = req.write_data;
								endcase
							end
						end
					end
					REG_DRIVE_HEAD: if (any_on()) drive_head = req.write_data | DH_FIXED_BITS;
					REG_CMD_STATUS: if (any_on()) begin
						// Commands complete at once against the selected drive.
						command = req.write_data;
						shadow[d].sts[STS_ERR_BIT] = 1'b0;
						if (command == CMD_SET_FEATURES && features == FEAT_PIO8) begin
							pio8[d] = 1'b1;
						end else begin
							shadow[d].err = ERR_ABORT;
							shadow[d].sts[STS_ERR_BIT] = 1'b1;
						end
						irq_flag = 1'b1;
					end
					REG_DEV_CTRL: begin
						if (req.write_data[DC_SRST_BIT]) irq_flag = 1'b0;
						dev_ctrl = req.write_data;
					end
					default: ;
				endcase
			end
			REQ_BUS_RESET: reset_task_file();
			default: ;
		endcase
		res.irq_pending  = irq_flag;
		res.irq_disabled = dev_ctrl[DC_NIEN_BIT];
		res.pio8_mask    = pio8;
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		if (fail_count < 50) $display("ERROR at %0t: %s", $realtime, msg);
		fail_count++;
	endtask

	task automatic check_field(input string name, input logic [7:0] got,
		input logic [7:0] want, input tf_req_t req);
		if (got !== want)
			report_mismatch($sformatf("%s is %h, expected %h (type %0d reg %0d data %h)",
				name, got, want, req.req_type, req.reg_index, req.write_data));
	endtask

	// Results leave only after their request has been registered, so the oldest
	// expectation is retired before this edge's request is predicted.
	always @(posedge clk or negedge arst_n) begin
		awaited_t oldest;
		awaited_t fresh;
		if (!arst_n) begin
			present_cfg = DRIVES_RESET;
			dev_ctrl = '0;
			irq_flag = 1'b0;
			pio8 = '0;
			reset_task_file();
			awaited_responses.delete();
			fail_count = 0;
			results_checked = 0;
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) present_cfg = cfg_data;
			if (out_valid && out_ready) begin
				if (awaited_responses.size() == 0) begin
					report_mismatch($sformatf("result %h with no request outstanding", out_data));
				end else begin
					oldest = awaited_responses.pop_front();
					check_field("read_data", out_data.read_data, oldest.res.read_data, oldest.req);
					check_field("irq_pending", 8'(out_data.irq_pending),
						8'(oldest.res.irq_pending), oldest.req);
					check_field("irq_disabled", 8'(out_data.irq_disabled),
						8'(oldest.res.irq_disabled), oldest.req);
					check_field("pio8_mask", 8'(out_data.pio8_mask), 8'(oldest.res.pio8_mask),
						oldest.req);
					results_checked++;
				end
			end
			if (in_valid && in_ready) begin
				fresh.req = in_data;
				fresh.res = access_response(in_data);
				awaited_responses.push_back(fresh);
			end
			outstanding <= awaited_responses.size();
		end
	end

endmodule

FILE: dv/tb_ata_task_file_register_block.sv
`timescale 1ns / 1ps

module tb_ata_task_file_register_block;
	import ata_tf_pkg::*;

	localparam logic [1:0] REQ_UNUSED     = 2'd3;
	localparam logic [3:0] REG_DATA       = 4'd0;
	localparam logic [3:0] REG_CTRL_LAST  = 4'd15;
	localparam int         PHASE_ITEMS    = 150;
	localparam int         NUM_PHASES     = 7;
	localparam int         STALL_CYCLES   = 100;
	localparam int         WATCHDOG_LIMIT = 1000;
	localparam int         IDLE_PERCENT   = 13;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	tf_req_t    in_data;
	logic       out_valid;
	logic       out_ready;
	tf_result_t out_data;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [1:0] cfg_data;

	int         fail_count;
	int         results_checked;
	int         outstanding;

	int         type_count [4];
	int         n_sent = 0;
	int         n_settings = 0;
	int         stalls_asked = 0;
	int         stalls_done = 0;
	int         idle_cycles = 0;
	logic       no_gaps;

	ata_task_file_register_block u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	ata_task_file_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// End the run when no transaction of any kind completes for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("Watchdog: %0d cycles without a transaction", WATCHDOG_LIMIT);
			$display("tb_ata_task_file_register_block NOT OK");
			$finish;
		end
	end

	// Result side: random back-pressure, plus long hold-offs on request.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stalls_done != stalls_asked) begin
				stalls_done++;
				out_ready <= 1'b0;
				repeat (STALL_CYCLES) @(posedge clk);
			end else if (no_gaps) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= IDLE_PERCENT);
			end
		end
	end

	// Offers one request and returns at the edge where it is taken.
	task automatic host_access(input logic [1:0] kind, input logic [3:0] idx,
		input logic [7:0] value);
		while (!no_gaps && $urandom_range(99) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= {kind, idx, value};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		type_count[kind]++;
		n_sent++;
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// The presence register is only changed with the block drained.
	task automatic write_presence(input logic [1:0] value);
		wait_for_results();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	task automatic random_access();
		int         pick;
		logic [3:0] idx;
		logic [7:0] value;
		pick = $urandom_range(99);
		value = 8'($urandom_range(255));
		if ($urandom_range(3) == 0) begin
			idx = 4'($urandom_range(15));
		end else begin
			case ($urandom_range(7))
				0:       idx = REG_ERR_FEAT;
				1:       idx = REG_COUNT;
				2:       idx = REG_SECTOR;
				3:       idx = REG_CYL_LO;
				4:       idx = REG_CYL_HI;
				5:       idx = REG_DRIVE_HEAD;
				6:       idx = REG_CMD_STATUS;
				default: idx = REG_DEV_CTRL;
			endcase
		end
		if (pick < 2) begin
			host_access(REQ_UNUSED, idx, value);
		end else if (pick < 5) begin
			host_access(REQ_BUS_RESET, idx, value);
		end else if (pick < 45) begin
			host_access(REQ_READ, idx, value);
		end else begin
			// Keep soft reset rare so the drives stay reachable most of the time.
			if (idx == REG_DEV_CTRL && $urandom_range(3) != 0) value[DC_SRST_BIT] = 1'b0;
			if (idx == REG_CMD_STATUS && $urandom_range(1) == 0) value = CMD_SET_FEATURES;
			if (idx == REG_ERR_FEAT && $urandom_range(1) == 0) value = FEAT_PIO8;
			host_access(REQ_WRITE, idx, value);
		end
	endtask

	// Optional control write, drive select, features, SET FEATURES and a status poll.
	task automatic set_features_burst();
		logic [7:0] ctrl;
		if ($urandom_range(3) == 0) begin
			ctrl = 8'($urandom_range(255));
			ctrl[DC_SRST_BIT] = 1'b0;
			host_access(REQ_WRITE, REG_DEV_CTRL, ctrl);
		end
		host_access(REQ_WRITE, REG_DRIVE_HEAD, 8'($urandom_range(255)));
		host_access(REQ_WRITE, REG_ERR_FEAT,
			($urandom_range(4) == 0) ? 8'($urandom_range(255)) : FEAT_PIO8);
		host_access(REQ_WRITE, REG_CMD_STATUS, CMD_SET_FEATURES);
		host_access(REQ_READ, ($urandom_range(1) == 0) ? REG_CMD_STATUS : REG_DEV_CTRL,
			8'($urandom_range(255)));
	endtask

	initial begin
		int         phase;
		int         target;
		logic       paused;
		logic [1:0] presence;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		no_gaps   = 1'b0;
		paused    = 1'b0;
		foreach (type_count[i]) type_count[i] = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Reset values, the data port and shared register writes with drive 0 only.
		host_access(REQ_READ, REG_CMD_STATUS, BYTE_ZERO);
		host_access(REQ_READ, REG_DATA, BYTE_FLOAT);
		host_access(REQ_WRITE, REG_COUNT, BYTE_FLOAT);
		host_access(REQ_WRITE, REG_SECTOR, BYTE_ZERO);
		host_access(REQ_READ, REG_COUNT, BYTE_ZERO);

		// Missing drive 1 selected: status reads low, other registers float,
		// and a command still aborts against its copy.
		host_access(REQ_WRITE, REG_DRIVE_HEAD, 8'h01 << DH_DRIVE_BIT);
		host_access(REQ_READ, REG_CMD_STATUS, BYTE_ZERO);
		host_access(REQ_READ, REG_COUNT, BYTE_ZERO);
		host_access(REQ_WRITE, REG_CMD_STATUS, BYTE_ZERO);

		// SET FEATURES for 8-bit PIO on drive 0, then the two status ports.
		host_access(REQ_WRITE, REG_DRIVE_HEAD, BYTE_ZERO);
		host_access(REQ_WRITE, REG_ERR_FEAT, FEAT_PIO8);
		host_access(REQ_WRITE, REG_CMD_STATUS, CMD_SET_FEATURES);
		host_access(REQ_READ, REG_DEV_CTRL, BYTE_ZERO);
		host_access(REQ_READ, REG_CMD_STATUS, BYTE_ZERO);

		// Interrupt disable, then soft reset hiding every drive.
		host_access(REQ_WRITE, REG_DEV_CTRL, 8'h01 << DC_NIEN_BIT);
		host_access(REQ_READ, REG_ERR_FEAT, BYTE_ZERO);
		host_access(REQ_WRITE, REG_DEV_CTRL, 8'h01 << DC_SRST_BIT);
		host_access(REQ_READ, REG_CMD_STATUS, BYTE_ZERO);
		host_access(REQ_WRITE, REG_CMD_STATUS, CMD_SET_FEATURES);
		host_access(REQ_WRITE, REG_DEV_CTRL, BYTE_ZERO);

		// Bus reset, the unused request type and the top of the control block.
		host_access(REQ_BUS_RESET, REG_DATA, BYTE_ZERO);
		host_access(REQ_READ, REG_DRIVE_HEAD, BYTE_ZERO);
		host_access(REQ_UNUSED, REG_CTRL_LAST, BYTE_FLOAT);
		host_access(REQ_READ, REG_CTRL_LAST, BYTE_ZERO);

		// Random phases, each under its own drive presence setting.
		for (phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase)
				0, 4:    presence = 2'b11;
				1:       presence = 2'b00;
				2:       presence = 2'b10;
				3, 5:    presence = 2'b01;
				default: presence = 2'($urandom_range(3));
			endcase
			write_presence(presence);
			no_gaps <= (phase == 2);
			target = n_sent + PHASE_ITEMS;
			while (n_sent < target) begin
				if (phase == 4 && stalls_asked == 0 && n_sent >= target - PHASE_ITEMS / 2)
					stalls_asked <= stalls_asked + 1;
				if (phase == 5 && !paused && n_sent >= target - PHASE_ITEMS / 2) begin
					wait_for_results();
					paused = 1'b1;
				end
				if ($urandom_range(99) < 12) set_features_burst();
				else random_access();
			end
		end

		wait_for_results();
		repeat (4) @(posedge clk);
		@(negedge clk);
		$display("Covered %0d requests: %0d reads, %0d writes, %0d bus resets, %0d unused type,",
			n_sent, type_count[REQ_READ], type_count[REQ_WRITE], type_count[REQ_BUS_RESET],
			type_count[REQ_UNUSED]);
		$display("under %0d presence settings; %0d results compared, %0d long stalls, %0d errors.",
			n_settings, results_checked, stalls_done, fail_count);
		if (fail_count == 0) begin
			$display("tb_ata_task_file_register_block OK");
		end else begin
			$display("tb_ata_task_file_register_block NOT OK");
		end
		$finish;
	end

endmodule
